### hw/rtl/ffpa_pkg.sv
// Shared types and constants for the first-fit pool allocator.
// No dependencies.
`default_nettype none
package ffpa_pkg;

  localparam int FFPA_POOL_BYTES    = 4096;
  localparam int FFPA_GRANULE_BYTES = 8;

  localparam int TYPE_W  = 2;
  localparam int BYTES_W = 13;
  localparam int OFFI_W  = 13;
  localparam int OFFO_W  = 12;
  localparam int STAT_W  = 3;

  localparam logic [TYPE_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REINIT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_START = 3'd4;
  localparam logic [STAT_W-1:0] ST_DBL_FREE  = 3'd5;

  // per-granule marks held in each cell
  typedef struct packed {
    logic start;
    logic free;
  } gran_t;

endpackage
`default_nettype wire

### hw/rtl/ffpa_if.sv
// Valid/ready channel interfaces: request, result and config write.
// Depends on ffpa_pkg.
`default_nettype none
interface ffpa_req_if import ffpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [BYTES_W-1:0]  req_bytes;
  logic [OFFI_W-1:0]   free_offset;
  modport source (output valid, req_type, req_bytes, free_offset, input ready);
  modport sink   (input valid, req_type, req_bytes, free_offset, output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [OFFO_W-1:0]   block_offset;
  logic [BYTES_W-1:0]  block_bytes;
  modport source (output valid, status, block_offset, block_bytes, input ready);
  modport sink   (input valid, status, block_offset, block_bytes, output ready);
endinterface

interface ffpa_cfg_if import ffpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTES_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/first_fit_pool_allocator_core.sv
// First-fit pool allocator with coalescing, top level.
// Depends on ffpa_pkg, ffpa_if (interfaces) and ffpa_cell.
//
//  channel | dir | beat content                            | accept
//  in_ch   | in  | req_type, req_bytes, free_offset        | valid & ready
//  out_ch  | out | status, block_offset, block_bytes       | valid & ready
//  cfg_ch  | in  | data -> min_split_bytes                 | valid & ready (ready = 1)
//
// Sequence (accept to result beat): alloc and free make two laps of the cell ring
//   (read lap, close, decide, write lap), N = POOL_BYTES/GRANULE_BYTES granules
//   each, then load the result. No fit, not a block start and double free end
//   after the read lap. Reinit takes one write lap. Rejected sizes/offsets and
//   type 3 go straight to the result load. The next request is taken in the cycle
//   after the load. The ring shifts one granule per cycle past cell 0 in the laps.
// Reset: one free block starting at granule 0, min_split_bytes = 40.
// Stalls: a result waits in the output register; the next request is accepted
//   meanwhile and only stalls when its own result must be loaded.
// GRANULE_BYTES must be a power of two.
`default_nettype none
module first_fit_pool_allocator_core import ffpa_pkg::*; #(
  parameter int POOL_BYTES    = FFPA_POOL_BYTES,
  parameter int GRANULE_BYTES = FFPA_GRANULE_BYTES
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ffpa_req_if.sink    in_ch,
  ffpa_rsp_if.source  out_ch,
  ffpa_cfg_if.sink    cfg_ch
);
  localparam int N        = POOL_BYTES / GRANULE_BYTES;
  localparam int GS       = $clog2(GRANULE_BYTES);
  localparam int IW       = $clog2(N);
  localparam int CW       = IW + 1;
  localparam int POOL_EFF = N * GRANULE_BYTES;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CLOSE, S_DECIDE, S_WRITE, S_RESP
  } state_t;

  state_t              state_r;
  logic [TYPE_W-1:0]   op_r;
  logic [BYTES_W-1:0]  need_r;
  logic [BYTES_W-1:0]  min_split_r;
  logic [IW-1:0]       cnt_r;
  logic [CW-1:0]       goff_r;      // granule of block to free
  logic                found_r;
  logic [CW-1:0]       fg_r;        // chosen block start (alloc)
  logic [CW-1:0]       fe_r;        // block end
  logic [CW-1:0]       cur_g_r;
  logic                cur_free_r;
  logic                prevfree_r;
  logic                sg_r;        // start mark at freed granule
  logic                fgb_r;       // free mark at freed granule
  logic                efound_r;
  logic                nextfree_r;
  logic                split_r;
  logic [CW-1:0]       wend_r;
  logic [STAT_W-1:0]   res_st_r;
  logic [OFFO_W-1:0]   res_off_r;
  logic [BYTES_W-1:0]  res_bytes_r;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_st_r;
  logic [OFFO_W-1:0]   out_off_r;
  logic [BYTES_W-1:0]  out_bytes_r;

  // ---- cell ring: cell 0 shows granule cnt_r, head feeds cell N-1 ----
  gran_t chain_q [N];
  gran_t head_d;
  logic  shift_en;

  assign shift_en = (state_r == S_SCAN) || (state_r == S_WRITE);

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      if (k == N - 1) begin : g_last
        ffpa_cell #(.INIT_START(k == 0)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .d(head_d), .q(chain_q[k])
        );
      end else begin : g_mid
        ffpa_cell #(.INIT_START(k == 0)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .d(chain_q[k+1]),
          .q(chain_q[k])
        );
      end
    end
  endgenerate

  gran_t       tap;
  logic [CW-1:0] idx;       // granule index at the tap, N in the close step
  logic        boundary;
  logic        fit_hit;
  logic [CW-1:0] need_c;
  logic [CW-1:0] rem_g;
  logic        split_c;
  logic        in_acc;

  assign tap    = chain_q[0];
  assign idx    = (state_r == S_CLOSE) ? CW'(N) : {1'b0, cnt_r};
  assign need_c = need_r[CW-1:0];
  assign in_acc = in_ch.valid && in_ch.ready;

  // alloc: close the running block at a boundary and test the fit
  always_comb begin
    boundary = (state_r == S_CLOSE) || tap.start || (cnt_r == '0);
    fit_hit  = boundary && (idx != '0) && !found_r && cur_free_r &&
               (32'(idx - cur_g_r) >= 32'(need_r));
  end

  // split decision from the chosen block
  always_comb begin
    rem_g   = fe_r - fg_r - need_c;
    split_c = (rem_g != '0) && ((32'(rem_g) << GS) >= 32'(min_split_r));
  end

  // write-lap rewrite of the granule leaving cell 0
  always_comb begin
    head_d = tap;
    if (state_r == S_WRITE) begin
      case (op_r)
        REQ_ALLOC: begin
          if (idx >= fg_r && idx < wend_r) head_d.free = 1'b0;
          if (split_r && idx == wend_r) head_d.start = 1'b1;
        end
        REQ_FREE: begin
          if (idx >= goff_r && idx < fe_r) head_d.free = 1'b1;
          if (idx == goff_r && goff_r != '0 && prevfree_r) head_d.start = 1'b0;
          if (idx == fe_r && nextfree_r) head_d.start = 1'b0;
        end
        default: begin
          head_d.start = (idx == '0);
          head_d.free  = 1'b1;
        end
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_split_r <= BYTES_W'(40);
      cnt_r       <= '0;
    end else begin
      if (cfg_ch.valid) min_split_r <= cfg_ch.data;
      // the load in S_RESP owns out_valid_r in that state
      if (out_valid_r && out_ch.ready && state_r != S_RESP) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r        <= in_ch.req_type;
            cnt_r       <= '0;
            res_st_r    <= ST_OK;
            res_off_r   <= '0;
            res_bytes_r <= '0;
            case (in_ch.req_type)
              REQ_ALLOC: begin
                if (in_ch.req_bytes == '0 ||
                    (in_ch.req_bytes & BYTES_W'(GRANULE_BYTES - 1)) != '0) begin
                  res_st_r <= ST_BAD_SIZE;
                  state_r  <= S_RESP;
                end else begin
                  need_r     <= in_ch.req_bytes >> GS;
                  found_r    <= 1'b0;
                  cur_g_r    <= '0;
                  cur_free_r <= 1'b0;
                  state_r    <= S_SCAN;
                end
              end
              REQ_FREE: begin
                if (32'(in_ch.free_offset) >= 32'(POOL_EFF)) begin
                  res_st_r <= ST_RANGE;
                  state_r  <= S_RESP;
                end else if ((in_ch.free_offset & OFFI_W'(GRANULE_BYTES - 1)) != '0) begin
                  res_st_r <= ST_NOT_START;
                  state_r  <= S_RESP;
                end else begin
                  goff_r     <= CW'(in_ch.free_offset >> GS);
                  prevfree_r <= 1'b0;
                  efound_r   <= 1'b0;
                  fe_r       <= CW'(N);
                  nextfree_r <= 1'b0;
                  state_r    <= S_SCAN;
                end
              end
              REQ_REINIT: begin
                res_bytes_r <= BYTES_W'(POOL_EFF);
                state_r     <= S_WRITE;
              end
              default: state_r <= S_RESP;
            endcase
          end
        end

        S_SCAN, S_CLOSE: begin
          if (op_r == REQ_ALLOC) begin
            if (fit_hit) begin
              found_r <= 1'b1;
              fg_r    <= cur_g_r;
              fe_r    <= idx;
            end
            if (boundary) begin
              cur_g_r    <= idx;
              cur_free_r <= tap.free;
            end
          end else begin
            if (idx + CW'(1) == goff_r) prevfree_r <= tap.free;
            if (idx == goff_r) begin
              sg_r  <= tap.start;
              fgb_r <= tap.free;
            end
            if (idx > goff_r && !efound_r && tap.start && state_r == S_SCAN) begin
              efound_r   <= 1'b1;
              fe_r       <= idx;
              nextfree_r <= tap.free;
            end
          end
          if (state_r == S_CLOSE) begin
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + IW'(1);
            if (cnt_r == IW'(N - 1)) state_r <= S_CLOSE;
          end
        end

        S_DECIDE: begin
          cnt_r <= '0;
          if (op_r == REQ_ALLOC) begin
            if (!found_r) begin
              res_st_r <= ST_NO_FIT;
              state_r  <= S_RESP;
            end else begin
              split_r     <= split_c;
              wend_r      <= split_c ? fg_r + need_c : fe_r;
              res_off_r   <= OFFO_W'(32'(fg_r) << GS);
              res_bytes_r <= BYTES_W'(32'(split_c ? need_c : fe_r - fg_r) << GS);
              state_r     <= S_WRITE;
            end
          end else begin
            if (!sg_r) begin
              res_st_r <= ST_NOT_START;
              state_r  <= S_RESP;
            end else if (fgb_r) begin
              res_st_r <= ST_DBL_FREE;
              state_r  <= S_RESP;
            end else begin
              res_off_r   <= OFFO_W'(32'(goff_r) << GS);
              res_bytes_r <= BYTES_W'(32'(fe_r - goff_r) << GS);
              state_r     <= S_WRITE;
            end
          end
        end

        S_WRITE: begin
          cnt_r <= cnt_r + IW'(1);
          if (cnt_r == IW'(N - 1)) state_r <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= res_st_r;
            out_off_r   <= res_off_r;
            out_bytes_r <= res_bytes_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.block_offset = out_off_r;
  assign out_ch.block_bytes  = out_bytes_r;
endmodule
`default_nettype wire

### hw/rtl/ffpa_cell.sv
// One granule cell of the mark ring: holds start/free, shifts to neighbor.
// Depends on ffpa_pkg.
`default_nettype none
module ffpa_cell import ffpa_pkg::*; #(
  parameter bit INIT_START = 1'b0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  shift_en,
  input  wire gran_t d,
  output gran_t      q
);
  gran_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '{start: INIT_START, free: 1'b1};
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

### hw/rtl/ffpa_checker.sv
// Port-level checks for the allocator core, bound to the top level.
// Depends on ffpa_pkg and first_fit_pool_allocator_core.
`default_nettype none
module ffpa_checker import ffpa_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [STAT_W-1:0]  status,
  input wire logic [OFFO_W-1:0]  block_offset,
  input wire logic [BYTES_W-1:0] block_bytes
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(block_offset) &&
                                $stable(block_bytes))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> block_offset == '0 && block_bytes == '0)
    else $error("error result carries data");
endmodule

bind first_fit_pool_allocator_core ffpa_checker u_ffpa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .block_offset(out_ch.block_offset),
  .block_bytes(out_ch.block_bytes)
);
`default_nettype wire

### test/first_fit_pool_allocator_core_tb.sv
// Self-checking testbench for first_fit_pool_allocator_core.
// Depends on ffpa_pkg, the ffpa_if interfaces and the allocator RTL.
// Checks every result beat against an in-bench first-fit pool predictor.
`default_nettype none
module first_fit_pool_allocator_core_tb import ffpa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NGRAN      = FFPA_POOL_BYTES / FFPA_GRANULE_BYTES;
  localparam int STALL_MAX  = 20000;  // several ops plus the long hold-off
  localparam int HOLD_LONG  = 3000;
  localparam int TAIL_WAIT  = 2200;   // idle wait after the final drain

  localparam logic [TYPE_W-1:0] REQ_NOP = 2'd3;  // unused request type

  typedef struct {
    logic [TYPE_W-1:0]  kind;
    logic [BYTES_W-1:0] bytes;
    logic [OFFI_W-1:0]  offset;
  } req_t;

  typedef struct {
    logic [TYPE_W-1:0]  kind;
    logic [STAT_W-1:0]  status;
    logic [OFFO_W-1:0]  offset;
    logic [BYTES_W-1:0] bytes;
  } grant_t;

  logic clk;
  logic rst_n;

  ffpa_req_if in_ch();
  ffpa_rsp_if out_ch();
  ffpa_cfg_if cfg_ch();

  first_fit_pool_allocator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow pool state
  bit          blk_start [NGRAN];
  bit          blk_free  [NGRAN];
  int unsigned split_min;

  req_t        pending_reqs[$];
  grant_t      expected_grants[$];
  int unsigned live_offsets[$];   // offsets of blocks seen granted

  int  errors;
  bit  quiet;        // no idling on either side
  bit  hold_req;     // ask the receiver for one long hold-off
  int  stall_cycles;

  function automatic void pool_reset();
    for (int i = 0; i < NGRAN; i++) begin
      blk_start[i] = 1'b0;
      blk_free[i]  = 1'b1;
    end
    blk_start[0] = 1'b1;
  endfunction

  function automatic int unsigned run_end(int unsigned g);
    int unsigned e;
    e = g + 1;
    while (e < NGRAN && !blk_start[e]) e++;
    return e;
  endfunction

  // first-fit alloc / free with coalescing
  function automatic grant_t pool_apply(req_t r);
    grant_t      res;
    int unsigned need, g, e, rem, stop;
    res.kind   = r.kind;
    res.status = ST_OK;
    res.offset = '0;
    res.bytes  = '0;
    if (r.kind == REQ_ALLOC) begin
      if (r.bytes == 0 || (r.bytes % FFPA_GRANULE_BYTES) != 0) begin
        res.status = ST_BAD_SIZE;
        return res;
      end
      need = r.bytes / FFPA_GRANULE_BYTES;
      g = 0;
      while (g < NGRAN) begin
        e = run_end(g);
        if (blk_free[g] && (e - g) >= need) begin
          rem  = (e - g - need) * FFPA_GRANULE_BYTES;
          stop = e;
          // zero remainder never splits
          if (rem > 0 && rem >= split_min) begin
            stop = g + need;
            blk_start[stop] = 1'b1;
          end
          for (int i = g; i < stop; i++) blk_free[i] = 1'b0;
          res.offset = OFFO_W'(g * FFPA_GRANULE_BYTES);
          res.bytes  = BYTES_W'((stop - g) * FFPA_GRANULE_BYTES);
          return res;
        end
        g = e;
      end
      res.status = ST_NO_FIT;
    end else if (r.kind == REQ_FREE) begin
      if (r.offset >= FFPA_POOL_BYTES) res.status = ST_RANGE;
      else if ((r.offset % FFPA_GRANULE_BYTES) != 0) res.status = ST_NOT_START;
      else begin
        g = r.offset / FFPA_GRANULE_BYTES;
        if (!blk_start[g]) res.status = ST_NOT_START;
        else if (blk_free[g]) res.status = ST_DBL_FREE;
        else begin
          e = run_end(g);
          for (int i = g; i < e; i++) blk_free[i] = 1'b1;
          if (g > 0 && blk_free[g-1]) blk_start[g] = 1'b0;
          if (e < NGRAN && blk_free[e]) blk_start[e] = 1'b0;
          res.offset = OFFO_W'(r.offset);
          res.bytes  = BYTES_W'((e - g) * FFPA_GRANULE_BYTES);
        end
      end
    end else if (r.kind == REQ_REINIT) begin
      pool_reset();
      res.bytes = BYTES_W'(FFPA_POOL_BYTES);
    end
    // type three: all zero
    return res;
  endfunction

  // ---------------- request driver ----------------
  int drv_gap;
  always @(posedge clk) begin
    req_t   nxt;
    grant_t g;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nxt.kind   = in_ch.req_type;
        nxt.bytes  = in_ch.req_bytes;
        nxt.offset = in_ch.free_offset;
        g = pool_apply(nxt);
        expected_grants.push_back(g);
      end
      // hold the beat until it is taken
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          drv_gap = $urandom_range(0, 15);
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.req_type    <= nxt.kind;
          in_ch.req_bytes   <= nxt.bytes;
          in_ch.free_offset <= nxt.offset;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------
  int  mon_gap;
  bit  hold_started;
  always @(posedge clk) begin
    grant_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mon_gap = 0;
      hold_started = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: result beat with none expected: st=%0d off=%0d bytes=%0d",
                   $realtime, out_ch.status, out_ch.block_offset, out_ch.block_bytes);
          errors++;
        end else begin
          w = expected_grants.pop_front();
          if (out_ch.status !== w.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, w.status, out_ch.status);
            errors++;
          end
          if (out_ch.block_offset !== w.offset) begin
            $display("%0t: block_offset exp %0d got %0d", $realtime, w.offset,
                     out_ch.block_offset);
            errors++;
          end
          if (out_ch.block_bytes !== w.bytes) begin
            $display("%0t: block_bytes exp %0d got %0d", $realtime, w.bytes,
                     out_ch.block_bytes);
            errors++;
          end
          if (w.kind == REQ_REINIT) live_offsets.delete();
          else if (w.kind == REQ_ALLOC && w.status == ST_OK)
            live_offsets.push_back(w.offset);
        end
      end
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        mon_gap = HOLD_LONG;
      end
      if (mon_gap > 0) begin
        mon_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        mon_gap = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic queue_req(logic [TYPE_W-1:0] k, int unsigned b, int unsigned o);
    req_t r;
    r.kind   = k;
    r.bytes  = b[BYTES_W-1:0];
    r.offset = o[OFFI_W-1:0];
    @(negedge clk);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_grants.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_split(int unsigned v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v[BYTES_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    split_min = v;
  endtask

  // mostly well-formed alloc/free traffic against blocks seen granted
  task automatic random_traffic(int n, bit mid_pause);
    int unsigned pick, sel, sz;
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() > 1) @(negedge clk);
      if (mid_pause && i == n / 2) drain();
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        case ($urandom_range(0, 9))
          0:       sz = $urandom_range(0, 8191);
          1:       sz = $urandom_range(1, 512) * FFPA_GRANULE_BYTES;
          default: sz = $urandom_range(1, 32) * FFPA_GRANULE_BYTES;
        endcase
        queue_req(REQ_ALLOC, sz, $urandom_range(0, 8191));
      end else if (sel < 92) begin
        if (live_offsets.size() > 0 && $urandom_range(0, 9) < 8) begin
          pick = $urandom_range(0, live_offsets.size() - 1);
          queue_req(REQ_FREE, $urandom_range(0, 8191), live_offsets[pick]);
          live_offsets.delete(pick);
        end else begin
          queue_req(REQ_FREE, $urandom_range(0, 8191), $urandom_range(0, 8191));
        end
      end else if (sel < 96) begin
        queue_req(REQ_REINIT, $urandom_range(0, 8191), $urandom_range(0, 8191));
      end else begin
        queue_req(REQ_NOP, $urandom_range(0, 8191), $urandom_range(0, 8191));
      end
    end
  endtask

  initial begin
    int tail;
    errors       = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    stall_cycles = 0;
    split_min    = 40;
    pool_reset();
    rst_n        = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every request type, error codes, split and merge edges
    queue_req(REQ_ALLOC, 0, 0);             // zero size
    queue_req(REQ_ALLOC, 4, 0);             // unaligned size
    queue_req(REQ_ALLOC, 8191, 8191);       // unaligned, all bits set
    queue_req(REQ_ALLOC, 4096, 0);          // whole pool, zero remainder
    queue_req(REQ_ALLOC, 8, 0);             // no fit
    queue_req(REQ_FREE, 0, 4096);           // past the pool
    queue_req(REQ_FREE, 0, 8191);           // past the pool
    queue_req(REQ_FREE, 0, 3);              // off-granule
    queue_req(REQ_FREE, 0, 8);              // not a block start
    queue_req(REQ_FREE, 0, 0);              // release whole pool
    queue_req(REQ_FREE, 0, 0);              // already free
    queue_req(REQ_ALLOC, 8, 0);             // split off 4088
    queue_req(REQ_ALLOC, 4056, 0);          // remainder 32 < 40: no split
    queue_req(REQ_ALLOC, 8, 0);             // no fit
    queue_req(REQ_FREE, 0, 8);              // free, no merge: left block in use
    queue_req(REQ_ALLOC, 16, 0);            // split again
    queue_req(REQ_FREE, 0, 0);              // free, no merge: right block in use
    queue_req(REQ_FREE, 0, 8);              // free block at 8: merge both sides
    queue_req(REQ_NOP, 8191, 8191);         // no-op type
    queue_req(REQ_REINIT, 8191, 8191);
    queue_req(REQ_ALLOC, 8184, 0);          // too large
    queue_req(REQ_ALLOC, 4088, 0);          // remainder 8 < 40
    queue_req(REQ_FREE, 0, 0);
    drain();

    write_split(8);
    queue_req(REQ_ALLOC, 4088, 0);          // remainder 8 splits now
    queue_req(REQ_ALLOC, 8, 0);
    hold_req = 1'b1;                        // receiver holds off; inputs back up
    random_traffic(230, 1'b0);
    drain();

    write_split(4096);
    random_traffic(220, 1'b1);              // sender pauses until all results
    drain();

    write_split(0);                         // zero remainder still no split
    queue_req(REQ_REINIT, 0, 0);
    queue_req(REQ_ALLOC, 4096, 0);
    random_traffic(220, 1'b0);
    drain();

    write_split($urandom_range(8, 4096) & 13'h1FF8);
    random_traffic(220, 1'b0);
    drain();

    write_split(8191);
    random_traffic(60, 1'b0);
    drain();
    write_split(40);
    quiet = 1'b1;                           // tail with no idling
    random_traffic(160, 1'b0);
    drain();

    tail = 0;
    while (tail < TAIL_WAIT) begin
      @(posedge clk);
      tail++;
    end
    if (errors == 0 && expected_grants.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_if.sv
hw/rtl/ffpa_cell.sv
hw/rtl/first_fit_pool_allocator_core.sv
hw/rtl/ffpa_checker.sv
test/first_fit_pool_allocator_core_tb.sv
